// File: rtl/vri_pkg.sv
// vri_pkg: shared types and constants for the video register interface.
// No dependencies. Used by the sprite store, the top level and the bench.
package vri_pkg;

  typedef enum logic [2:0] {
    OP_CPU_READ     = 3'd0,
    OP_CPU_WRITE    = 3'd1,
    OP_PEEK         = 3'd2,
    OP_VBLANK       = 3'd3,
    OP_PRERENDER    = 3'd4,
    OP_SPRITE_FLAGS = 3'd5
  } vri_op_t;

  typedef enum logic [2:0] {
    REG_CONTROL  = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDRESS  = 3'd6,
    REG_DATA     = 3'd7
  } vri_reg_t;

  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam logic [14:0] ADDR_INC_ROW = 15'd32;
  localparam logic [14:0] ADDR_INC_COL = 15'd1;

  // Sprite store port control, driven by the top level.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_addr;
  } vri_oam_ctl_t;

endpackage

// File: rtl/vri_in_if.sv
// vri_in_if: input channel, one CPU access or frame event per word.
// No dependencies.
interface vri_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [2:0] reg_index;
  logic [7:0] write_byte;
  logic [7:0] memory_byte;
  logic       overflow_flag;
  logic       zero_hit_flag;

  modport source (output valid, operation, reg_index, write_byte, memory_byte,
                  overflow_flag, zero_hit_flag, input ready);
  modport sink   (input valid, operation, reg_index, write_byte, memory_byte,
                  overflow_flag, zero_hit_flag, output ready);
endinterface

// File: rtl/vri_out_if.sv
// vri_out_if: result channel, one result word per accepted input word.
// No dependencies.
interface vri_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [13:0] mem_address;
  logic        mem_read;
  logic        mem_write;
  logic [7:0]  mem_data;
  logic        nmi;
  logic [14:0] render_address;
  logic [2:0]  fine_scroll;
  logic [7:0]  control_bits;
  logic [7:0]  mask_bits;

  modport source (output valid, read_byte, mem_address, mem_read, mem_write, mem_data,
                  nmi, render_address, fine_scroll, control_bits, mask_bits,
                  input ready);
  modport sink   (input valid, read_byte, mem_address, mem_read, mem_write, mem_data,
                  nmi, render_address, fine_scroll, control_bits, mask_bits,
                  output ready);
endinterface

// File: rtl/video_register_interface.sv
// video_register_interface: CPU-side register file of a tile video unit.
// Depends on vri_pkg, vri_in_if, vri_out_if and vri_oam.
//
// Takes one word per clock: a CPU read, write or debug peek of one of eight
// registers, or a frame event (vblank start, prerender clear, sprite flags).
// Every accepted word yields exactly one result word, registered, valid the
// cycle after acceptance; a new word is accepted each cycle that the result
// register is empty or being drained. The sprite store is a 256-byte memory
// whose registered read port is always aimed at the pointer the next word
// will see, so sprite data reads also run at one word per cycle.
module video_register_interface
  import vri_pkg::*;
#(
  parameter int SPRITE_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  vri_in_if.sink    in_ch,
  vri_out_if.source out_ch
);

  logic [7:0]  control_r, control_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  rbuf_r, rbuf_nxt;
  logic        toggle_r, toggle_nxt;
  logic [2:0]  finex_r, finex_nxt;
  logic [14:0] taddr_r, taddr_nxt;
  logic [14:0] vaddr_r, vaddr_nxt;
  logic [7:0]  sptr_r, sptr_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rb_r, rb_nxt;
  logic [13:0] maddr_r;
  logic        mrd_r, mrd_nxt;
  logic        mwr_r, mwr_nxt;
  logic [7:0]  md_r, md_nxt;
  logic        nmi_r, nmi_nxt;
  logic [14:0] raddr_r;
  logic [2:0]  fine_r;
  logic [7:0]  ctrl_out_r;
  logic [7:0]  mask_out_r;

  logic         in_acc;
  logic [13:0]  maddr;
  logic [14:0]  vaddr_step;
  logic [7:0]   oam_rd;
  vri_oam_ctl_t oam_ctl;
  vri_op_t      op;
  vri_reg_t     rsel;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign op          = vri_op_t'(in_ch.operation);
  assign rsel        = vri_reg_t'(in_ch.reg_index);
  assign maddr       = vaddr_r[13:0];
  assign vaddr_step  = vaddr_r + (control_r[2] ? ADDR_INC_ROW : ADDR_INC_COL);

  vri_oam #(
    .DEPTH (SPRITE_BYTES)
  ) u_oam (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (oam_ctl),
    .rd_data (oam_rd)
  );

  always_comb begin
    control_nxt = control_r;
    mask_nxt    = mask_r;
    status_nxt  = status_r;
    rbuf_nxt    = rbuf_r;
    toggle_nxt  = toggle_r;
    finex_nxt   = finex_r;
    taddr_nxt   = taddr_r;
    vaddr_nxt   = vaddr_r;
    sptr_nxt    = sptr_r;
    rb_nxt      = 8'h00;
    mrd_nxt     = 1'b0;
    mwr_nxt     = 1'b0;
    md_nxt      = 8'h00;
    nmi_nxt     = 1'b0;
    oam_ctl.wr_en   = 1'b0;
    oam_ctl.wr_addr = sptr_r;
    oam_ctl.wr_data = in_ch.write_byte;
    if (in_acc) begin
      case (op)
        OP_CPU_READ: begin
          case (rsel)
            REG_STATUS: begin
              rb_nxt     = {status_r, rbuf_r[4:0]};
              status_nxt = {1'b0, status_r[1:0]};
              toggle_nxt = 1'b0;
            end
            REG_OAM_DATA: rb_nxt = oam_rd;
            REG_DATA: begin
              rb_nxt    = (maddr >= PALETTE_BASE) ? in_ch.memory_byte : rbuf_r;
              rbuf_nxt  = in_ch.memory_byte;
              mrd_nxt   = 1'b1;
              vaddr_nxt = vaddr_step;
            end
            default: ;
          endcase
        end
        OP_CPU_WRITE: begin
          case (rsel)
            REG_CONTROL: begin
              control_nxt = in_ch.write_byte;
              taddr_nxt   = {taddr_r[14:12], in_ch.write_byte[1:0], taddr_r[9:0]};
            end
            REG_MASK:     mask_nxt = in_ch.write_byte;
            REG_OAM_ADDR: sptr_nxt = in_ch.write_byte;
            REG_OAM_DATA: begin
              oam_ctl.wr_en = 1'b1;
              sptr_nxt      = sptr_r + 8'd1;
            end
            REG_SCROLL: begin
              if (!toggle_r) begin
                finex_nxt  = in_ch.write_byte[2:0];
                taddr_nxt  = {taddr_r[14:5], in_ch.write_byte[7:3]};
                toggle_nxt = 1'b1;
              end else begin
                taddr_nxt  = {in_ch.write_byte[2:0], taddr_r[11:10],
                              in_ch.write_byte[7:3], taddr_r[4:0]};
                toggle_nxt = 1'b0;
              end
            end
            REG_ADDRESS: begin
              if (!toggle_r) begin
                taddr_nxt  = {1'b0, in_ch.write_byte[5:0], taddr_r[7:0]};
                toggle_nxt = 1'b1;
              end else begin
                taddr_nxt  = {taddr_r[14:8], in_ch.write_byte};
                vaddr_nxt  = {taddr_r[14:8], in_ch.write_byte};
                toggle_nxt = 1'b0;
              end
            end
            REG_DATA: begin
              mwr_nxt   = 1'b1;
              md_nxt    = in_ch.write_byte;
              vaddr_nxt = vaddr_step;
            end
            default: ;
          endcase
        end
        OP_PEEK: begin
          case (rsel)
            REG_CONTROL:  rb_nxt = control_r;
            REG_MASK:     rb_nxt = mask_r;
            REG_STATUS:   rb_nxt = {status_r, 5'b00000};
            REG_OAM_DATA: rb_nxt = oam_rd;
            default:      rb_nxt = 8'h00;
          endcase
        end
        OP_VBLANK: begin
          status_nxt = {1'b1, status_r[1:0]};
          nmi_nxt    = control_r[7];
        end
        OP_PRERENDER:    status_nxt = 3'b000;
        OP_SPRITE_FLAGS: begin
          status_nxt = status_r | {1'b0, in_ch.zero_hit_flag, in_ch.overflow_flag};
        end
        default: ;
      endcase
    end
    // read port follows the pointer the next word will use
    oam_ctl.rd_addr = sptr_nxt;
  end

  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= 8'h00;
      mask_r      <= 8'h00;
      status_r    <= 3'b000;
      rbuf_r      <= 8'h00;
      toggle_r    <= 1'b0;
      finex_r     <= 3'b000;
      taddr_r     <= 15'h0000;
      vaddr_r     <= 15'h0000;
      sptr_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      control_r   <= control_nxt;
      mask_r      <= mask_nxt;
      status_r    <= status_nxt;
      rbuf_r      <= rbuf_nxt;
      toggle_r    <= toggle_nxt;
      finex_r     <= finex_nxt;
      taddr_r     <= taddr_nxt;
      vaddr_r     <= vaddr_nxt;
      sptr_r      <= sptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rb_r       <= rb_nxt;
      maddr_r    <= maddr;
      mrd_r      <= mrd_nxt;
      mwr_r      <= mwr_nxt;
      md_r       <= md_nxt;
      nmi_r      <= nmi_nxt;
      raddr_r    <= vaddr_nxt;
      fine_r     <= finex_nxt;
      ctrl_out_r <= control_nxt;
      mask_out_r <= mask_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_byte      = rb_r;
  assign out_ch.mem_address    = maddr_r;
  assign out_ch.mem_read       = mrd_r;
  assign out_ch.mem_write      = mwr_r;
  assign out_ch.mem_data       = md_r;
  assign out_ch.nmi            = nmi_r;
  assign out_ch.render_address = raddr_r;
  assign out_ch.fine_scroll    = fine_r;
  assign out_ch.control_bits   = ctrl_out_r;
  assign out_ch.mask_bits      = mask_out_r;

endmodule

// File: rtl/vri_oam.sv
// vri_oam: sprite attribute store, one write and one registered read port.
// Depends on vri_pkg. Per-entry valid bits make unwritten entries read as zero.
module vri_oam
  import vri_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  vri_oam_ctl_t ctl,
  output logic [7:0]   rd_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [7:0]       rd_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr[IDX_W-1:0]] <= ctl.wr_data;
    end
    rd_r <= mem[ctl.rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
      rd_valid_r <= valid_r[ctl.rd_addr[IDX_W-1:0]];
    end
  end

  assign rd_data = rd_valid_r ? rd_r : 8'h00;

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for video_register_interface (CPU register file).
// Depends on vri_pkg, vri_in_if, vri_out_if and the RTL of the block.
// Drives directed then random access sequences, predicts every result word.
`timescale 1ns / 100ps

module tb_top;
  import vri_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_WORDS = 1650;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] reg_idx;
    logic [7:0] wr_byte;
    logic [7:0] mem_byte;
    logic       ovf;
    logic       hit;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  rd_byte;
    logic [13:0] mem_addr;
    logic        mem_rd;
    logic        mem_wr;
    logic [7:0]  mem_dat;
    logic        nmi_out;
    logic [14:0] rnd_addr;
    logic [2:0]  fine;
    logic [7:0]  ctrl;
    logic [7:0]  mask_bits;
  } result_t;

  // Register file predictor plus the queue of result words still owed.
  class vri_result_checker;
    logic [7:0]  ctrl_q, mask_q, rbuf_q, oam_ptr_q;
    logic [2:0]  flags_q, fine_x_q;
    logic        toggle_q;
    logic [14:0] t_addr_q, v_addr_q;
    logic [7:0]  oam_mem [256];
    result_t     pending_results[$];
    int unsigned fail_count;

    function new();
      ctrl_q = '0; mask_q = '0; rbuf_q = '0; oam_ptr_q = '0;
      flags_q = '0; fine_x_q = '0; toggle_q = 1'b0;
      t_addr_q = '0; v_addr_q = '0; fail_count = 0;
      foreach (oam_mem[i]) oam_mem[i] = '0;
    endfunction

    function void step_v();
      v_addr_q = v_addr_q + (ctrl_q[2] ? ADDR_INC_ROW : ADDR_INC_COL);
    endfunction

    function void accept_word(in_word_t w);
      result_t r;
      r = '0;
      r.mem_addr = v_addr_q[13:0];
      case (w.op)
        OP_CPU_READ: begin
          case (w.reg_idx)
            REG_STATUS: begin
              r.rd_byte = {flags_q, rbuf_q[4:0]};
              flags_q[2] = 1'b0;
              toggle_q = 1'b0;
            end
            REG_OAM_DATA: r.rd_byte = oam_mem[oam_ptr_q];
            REG_DATA: begin
              r.rd_byte = (v_addr_q[13:0] >= PALETTE_BASE) ? w.mem_byte : rbuf_q;
              rbuf_q = w.mem_byte;
              r.mem_rd = 1'b1;
              step_v();
            end
            default: ;
          endcase
        end
        OP_CPU_WRITE: begin
          case (w.reg_idx)
            REG_CONTROL: begin
              ctrl_q = w.wr_byte;
              t_addr_q = {t_addr_q[14:12], w.wr_byte[1:0], t_addr_q[9:0]};
            end
            REG_MASK: mask_q = w.wr_byte;
            REG_OAM_ADDR: oam_ptr_q = w.wr_byte;
            REG_OAM_DATA: begin
              oam_mem[oam_ptr_q] = w.wr_byte;
              oam_ptr_q = oam_ptr_q + 8'd1;
            end
            REG_SCROLL: begin
              if (!toggle_q) begin
                fine_x_q = w.wr_byte[2:0];
                t_addr_q = {t_addr_q[14:5], w.wr_byte[7:3]};
              end else begin
                t_addr_q = {w.wr_byte[2:0], t_addr_q[11:10], w.wr_byte[7:3], t_addr_q[4:0]};
              end
              toggle_q = !toggle_q;
            end
            REG_ADDRESS: begin
              if (!toggle_q) begin
                t_addr_q = {1'b0, w.wr_byte[5:0], t_addr_q[7:0]};
              end else begin
                t_addr_q = {t_addr_q[14:8], w.wr_byte};
                v_addr_q = t_addr_q;
              end
              toggle_q = !toggle_q;
            end
            REG_DATA: begin
              r.mem_wr = 1'b1;
              r.mem_dat = w.wr_byte;
              step_v();
            end
            default: ;
          endcase
        end
        OP_PEEK: begin
          case (w.reg_idx)
            REG_CONTROL: r.rd_byte = ctrl_q;
            REG_MASK: r.rd_byte = mask_q;
            REG_STATUS: r.rd_byte = {flags_q, 5'd0};
            REG_OAM_DATA: r.rd_byte = oam_mem[oam_ptr_q];
            default: ;
          endcase
        end
        OP_VBLANK: begin
          flags_q[2] = 1'b1;
          r.nmi_out = ctrl_q[7];
        end
        OP_PRERENDER: flags_q = '0;
        OP_SPRITE_FLAGS: flags_q = flags_q | {1'b0, w.hit, w.ovf};
        default: ;
      endcase
      r.rnd_addr = v_addr_q;
      r.fine = fine_x_q;
      r.ctrl = ctrl_q;
      r.mask_bits = mask_q;
      pending_results.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        fail_count++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual read_byte 0x%0h",
                 $time, got.rd_byte);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare("read_byte", 32'(want.rd_byte), 32'(got.rd_byte));
      compare("mem_address", 32'(want.mem_addr), 32'(got.mem_addr));
      compare("mem_read", 32'(want.mem_rd), 32'(got.mem_rd));
      compare("mem_write", 32'(want.mem_wr), 32'(got.mem_wr));
      compare("mem_data", 32'(want.mem_dat), 32'(got.mem_dat));
      compare("nmi", 32'(want.nmi_out), 32'(got.nmi_out));
      compare("render_address", 32'(want.rnd_addr), 32'(got.rnd_addr));
      compare("fine_scroll", 32'(want.fine), 32'(got.fine));
      compare("control_bits", 32'(want.ctrl), 32'(got.ctrl));
      compare("mask_bits", 32'(want.mask_bits), 32'(got.mask_bits));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_req;
  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned rx_phase;
  int unsigned hold_left;
  int unsigned cycle_count;
  result_t seen;
  vri_result_checker reg_check;

  vri_in_if  in_ch();
  vri_out_if out_ch();

  video_register_interface DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.rd_byte = out_ch.read_byte;
      seen.mem_addr = out_ch.mem_address;
      seen.mem_rd = out_ch.mem_read;
      seen.mem_wr = out_ch.mem_write;
      seen.mem_dat = out_ch.mem_data;
      seen.nmi_out = out_ch.nmi;
      seen.rnd_addr = out_ch.render_address;
      seen.fine = out_ch.fine_scroll;
      seen.ctrl = out_ch.control_bits;
      seen.mask_bits = out_ch.mask_bits;
      reg_check.check_word(seen);
    end
  end

  // Result side: stall pattern steps through four modes picked by rx_phase[9:8]; long hold on request.
  initial begin
    out_ch.ready = 1'b0;
    rx_phase = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_phase[9:8])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= ($urandom_range(0, 9) > 2);
          2'd2: out_ch.ready <= ((rx_phase % 6) != 0) && ((rx_phase % 11) > 2);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 20);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= w.op;
    in_ch.reg_index <= w.reg_idx;
    in_ch.write_byte <= w.wr_byte;
    in_ch.memory_byte <= w.mem_byte;
    in_ch.overflow_flag <= w.ovf;
    in_ch.zero_hit_flag <= w.hit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reg_check.accept_word(w);
    words_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send(input logic [2:0] op, input logic [2:0] ri, input logic [7:0] wb);
    in_word_t w;
    w.op = op;
    w.reg_idx = ri;
    w.wr_byte = wb;
    w.mem_byte = 8'($urandom_range(0, 255));
    w.ovf = 1'($urandom_range(0, 1));
    w.hit = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (reg_check.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    burst_left = 0;
  endtask

  task automatic run_directed();
    in_word_t w;
    send(OP_PEEK, REG_CONTROL, 8'h00);
    send(OP_PEEK, REG_STATUS, 8'h00);
    send(OP_PEEK, REG_SCROLL, 8'hFF);
    send(OP_CPU_WRITE, REG_CONTROL, 8'hFF);
    send(OP_VBLANK, REG_CONTROL, 8'h00);
    w = '{op: OP_SPRITE_FLAGS, reg_idx: REG_STATUS, wr_byte: 8'h00, mem_byte: 8'hFF,
          ovf: 1'b1, hit: 1'b1};
    send_word(w);
    send(OP_PEEK, REG_STATUS, 8'h00);
    send(OP_CPU_READ, REG_STATUS, 8'h00);
    send(OP_PRERENDER, REG_CONTROL, 8'h00);
    send(OP_CPU_WRITE, REG_STATUS, 8'hFF);
    send(OP_CPU_READ, REG_ADDRESS, 8'h00);
    send(OP_CPU_WRITE, REG_MASK, 8'hFF);
    // sprite pointer wraps past the top of the store
    send(OP_CPU_WRITE, REG_OAM_ADDR, 8'hFF);
    send(OP_CPU_WRITE, REG_OAM_DATA, 8'hA5);
    send(OP_CPU_WRITE, REG_OAM_ADDR, 8'hFF);
    send(OP_CPU_READ, REG_OAM_DATA, 8'h00);
    // current address to 0x7FFF, then a data write wraps it to zero
    send(OP_CPU_WRITE, REG_CONTROL, 8'h03);
    send(OP_VBLANK, REG_MASK, 8'h00);
    send(OP_CPU_WRITE, REG_SCROLL, 8'hF8);
    send(OP_CPU_WRITE, REG_SCROLL, 8'hFF);
    send(OP_CPU_WRITE, REG_SCROLL, 8'hFF);
    send(OP_CPU_WRITE, REG_ADDRESS, 8'hFF);
    send(OP_CPU_WRITE, REG_DATA, 8'h5A);
    // palette read bypasses the buffer
    send(OP_CPU_WRITE, REG_ADDRESS, 8'h3F);
    send(OP_CPU_WRITE, REG_ADDRESS, 8'h00);
    send(OP_CPU_READ, REG_DATA, 8'h00);
    send(OP_SPARE_LO, REG_DATA, 8'hFF);
    send(OP_SPARE_HI, REG_CONTROL, 8'hFF);
  endtask

  task automatic send_data_run(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) != 0) send(OP_CPU_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
      else send(OP_CPU_READ, REG_DATA, 8'h00);
    end
  endtask

  task automatic run_random();
    int unsigned pick;
    int unsigned stop_at;
    logic [7:0] b;
    in_word_t w;
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      if (!held && words_sent > 500) begin
        hold_req <= 1'b1;
        held = 1'b1;
      end
      if (!drained && words_sent > 1100) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        if ($urandom_range(0, 1) != 0) send(OP_CPU_READ, REG_STATUS, 8'h00);
        send(OP_CPU_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
        send(OP_CPU_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
        send(OP_PEEK, 3'($urandom_range(0, 7)), 8'h00);
      end else if (pick < 40) begin
        send(OP_CPU_READ, REG_STATUS, 8'h00);
        if ($urandom_range(0, 1) != 0)
          send(OP_CPU_WRITE, REG_CONTROL, 8'($urandom_range(0, 255)));
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) b[5:0] = 6'h3F;
        send(OP_CPU_WRITE, REG_ADDRESS, b);
        send(OP_CPU_WRITE, REG_ADDRESS, 8'($urandom_range(0, 255)));
        send_data_run($urandom_range(1, 8));
      end else if (pick < 54) begin
        b = 8'($urandom_range(0, 255));
        send(OP_CPU_WRITE, REG_OAM_ADDR, b);
        for (int unsigned i = $urandom_range(1, 6); i > 0; i--)
          send(OP_CPU_WRITE, REG_OAM_DATA, 8'($urandom_range(0, 255)));
        send(OP_CPU_WRITE, REG_OAM_ADDR, 8'(b + $urandom_range(0, 3)));
        send(OP_CPU_READ, REG_OAM_DATA, 8'h00);
        send(OP_PEEK, REG_OAM_DATA, 8'h00);
      end else if (pick < 70) begin
        for (int unsigned i = $urandom_range(2, 6); i > 0; i--) begin
          case ($urandom_range(0, 5))
            0: send(OP_VBLANK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            1: send(OP_SPRITE_FLAGS, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            2: send(OP_CPU_READ, REG_STATUS, 8'h00);
            3: send(OP_PEEK, REG_STATUS, 8'h00);
            4: send(OP_PRERENDER, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            default: send(OP_CPU_WRITE, REG_CONTROL, 8'($urandom_range(0, 255)));
          endcase
        end
      end else if (pick < 80) begin
        send(OP_CPU_WRITE, REG_CONTROL, 8'($urandom_range(0, 255)));
        send(OP_CPU_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
        send(OP_PEEK, 3'($urandom_range(0, 7)), 8'h00);
      end else if (pick < 90) begin
        // park the current address near the top so the steps may wrap
        send(OP_CPU_READ, REG_STATUS, 8'h00);
        b = 8'($urandom_range(0, 255));
        b[1:0] = 2'b11;
        send(OP_CPU_WRITE, REG_CONTROL, b);
        b = 8'($urandom_range(0, 255));
        b[7:3] = 5'h1F;
        send(OP_CPU_WRITE, REG_SCROLL, b);
        b = 8'($urandom_range(0, 255));
        b = b | 8'hFF;
        send(OP_CPU_WRITE, REG_SCROLL, b);
        send(OP_CPU_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
        b = 8'($urandom_range(0, 255));
        b[7:5] = 3'h7;
        send(OP_CPU_WRITE, REG_ADDRESS, b);
        send_data_run($urandom_range(2, 8));
      end else begin
        w.op = 3'($urandom_range(0, 7));
        w.reg_idx = 3'($urandom_range(0, 7));
        w.wr_byte = 8'($urandom_range(0, 255));
        w.mem_byte = 8'($urandom_range(0, 255));
        w.ovf = 1'($urandom_range(0, 1));
        w.hit = 1'($urandom_range(0, 1));
        send_word(w);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    words_sent = 0;
    cycle_count = 0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.reg_index = '0;
    in_ch.write_byte = '0;
    in_ch.memory_byte = '0;
    in_ch.overflow_flag = 1'b0;
    in_ch.zero_hit_flag = 1'b0;
    reg_check = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    while (reg_check.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (reg_check.fail_count == 0 && reg_check.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
